### design/hpcs_pkg.sv
// Package for the sign-prefiltered cosine similarity block.
// Holds widths, limits, the controller state type and the command/status structs.
// No dependencies.
package hpcs_pkg;

  // Largest number of elements taken into one vector.
  localparam int MAX_DIM = 512;

  // Field widths.
  localparam int ELEM_W  = 16;
  localparam int NORM_W  = 20;
  localparam int MISM_W  = 10;
  localparam int SIM_W   = 16;
  localparam int PROD_W  = 2 * ELEM_W;
  localparam int ACC_W   = 42;
  localparam int DEN_W   = 2 * NORM_W;

  // Element and mismatch counters hold values up to MAX_DIM.
  localparam int CNT_W   = $clog2(MAX_DIM + 1);
  localparam int CMP_W   = (CNT_W > MISM_W) ? CNT_W : MISM_W;

  // Divider: dividend is |dot| << 16 plus the denominator, divisor is twice it.
  localparam int FRAC_SH   = 16;
  localparam int DVD_W     = ACC_W + FRAC_SH;
  localparam int DVS_W     = DEN_W + 1;
  localparam int QUO_W     = SIM_W + 1;
  localparam int DIV_STEPS = DVD_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Reset value of the mismatch limit.
  localparam logic [MISM_W-1:0] MAX_MISMATCH_RST = MISM_W'(64);

  // Controller states.
  typedef enum logic [2:0] {
    S_ACCUM,
    S_NORM,
    S_PREP,
    S_DIV,
    S_FINISH
  } hpcs_state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic take;
    logic norm;
    logic prep;
    logic step;
    logic finish;
  } hpcs_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic div_last;
    logic out_free;
  } hpcs_status_t;

endpackage

### design/hpcs_if.sv
// Handshake channel interfaces of the cosine similarity block.
// Depends on hpcs_pkg for the field widths.

// Element request channel.
interface hpcs_in_if;
  import hpcs_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] query_elem;
  logic signed [ELEM_W-1:0] cand_elem;
  logic [NORM_W-1:0]        query_norm;
  logic [NORM_W-1:0]        cand_norm;
  logic                     last;
  modport source (output valid, query_elem, cand_elem, query_norm, cand_norm, last,
                  input ready);
  modport sink (input valid, query_elem, cand_elem, query_norm, cand_norm, last,
                output ready);
endinterface

// Result request channel.
interface hpcs_out_if;
  import hpcs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    passed;
  logic signed [SIM_W-1:0] similarity;
  logic [MISM_W-1:0]       mismatches;
  modport source (output valid, passed, similarity, mismatches, input ready);
  modport sink (input valid, passed, similarity, mismatches, output ready);
endinterface

// Configuration write channel for the mismatch limit.
interface hpcs_cfg_if;
  import hpcs_pkg::*;
  logic              valid;
  logic              ready;
  logic [MISM_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### design/hpcs_ctrl.sv
// Controller state machine of the cosine similarity block.
// Depends on hpcs_pkg for the state type and the command/status structs.
module hpcs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_last,
  output logic                 in_ready,
  input  hpcs_pkg::hpcs_status_t status,
  output hpcs_pkg::hpcs_cmd_t    cmd
);
  import hpcs_pkg::*;

  hpcs_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACCUM;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_ACCUM: begin
        if (in_valid && in_last) state_nxt = S_NORM;
      end
      S_NORM:  state_nxt = S_PREP;
      S_PREP:  state_nxt = S_DIV;
      S_DIV: begin
        if (status.div_last) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (status.out_free) state_nxt = S_ACCUM;
      end
      default: state_nxt = S_ACCUM;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    case (state_r)
      S_ACCUM: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      S_NORM:   cmd.norm = 1'b1;
      S_PREP:   cmd.prep = 1'b1;
      S_DIV:    cmd.step = 1'b1;
      S_FINISH: cmd.finish = status.out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### design/hpcs_datapath.sv
// Datapath: multiply-accumulate, sign mismatch count, norm product, bit-serial
// rounding divider, result register and mismatch limit register.
// Depends on hpcs_pkg and the channel interfaces in hpcs_if.sv.
module hpcs_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic signed [hpcs_pkg::ELEM_W-1:0] query_elem,
  input  logic signed [hpcs_pkg::ELEM_W-1:0] cand_elem,
  input  logic [hpcs_pkg::NORM_W-1:0]        query_norm,
  input  logic [hpcs_pkg::NORM_W-1:0]        cand_norm,
  input  hpcs_pkg::hpcs_cmd_t                cmd,
  output hpcs_pkg::hpcs_status_t             status,
  hpcs_out_if.source                         out_ch,
  hpcs_cfg_if.sink                           cfg_ch
);
  import hpcs_pkg::*;

  localparam logic signed [ACC_W:0] ACC_MAX_X = {2'b00, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W:0] ACC_MIN_X = {2'b11, {(ACC_W-1){1'b0}}};

  logic [MISM_W-1:0]        max_mismatch_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_vld_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [ACC_W:0]    acc_sum;
  logic [CNT_W-1:0]         elem_cnt_r;
  logic [CNT_W-1:0]         mism_cnt_r;
  logic                     elem_room;
  logic [NORM_W-1:0]        qn_r, cn_r;
  logic [DEN_W-1:0]         den_r;
  logic [ACC_W-1:0]         mag;
  logic                     neg_r;
  logic [DVD_W-1:0]         dvd_r;
  logic [DVS_W-1:0]         dvs_r;
  logic [DVS_W-1:0]         rem_r;
  logic [DVS_W:0]           rem_sh;
  logic [DVS_W:0]           rem_sub;
  logic                     rem_ge;
  logic [QUO_W-1:0]         quo_r;
  logic                     ovf_r;
  logic [STEP_W-1:0]        step_r;
  logic [CMP_W-1:0]         mism_ext;
  logic                     passed;
  logic                     nonzero_norm;
  logic [SIM_W-1:0]         sim_val;
  logic [MISM_W-1:0]        mism_out;
  logic                     out_valid_r;
  logic                     out_passed_r;
  logic signed [SIM_W-1:0]  out_sim_r;
  logic [MISM_W-1:0]        out_mism_r;

  // Mismatch limit register; writes are always taken.
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_mismatch_r <= MAX_MISMATCH_RST;
    end else if (cfg_ch.valid) begin
      max_mismatch_r <= cfg_ch.data;
    end
  end

  // Elements past the dimension limit are dropped apart from their last flag.
  assign elem_room = (elem_cnt_r < CNT_W'(MAX_DIM));

  // Product stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= cmd.take && elem_room;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && elem_room) begin
      prod_r <= query_elem * cand_elem;
    end
  end

  // Saturating accumulate of the registered product.
  always_comb begin
    acc_sum = {acc_r[ACC_W-1], acc_r} + (ACC_W+1)'(prod_r);
    if (acc_sum > ACC_MAX_X) begin
      acc_nxt = ACC_MAX_X[ACC_W-1:0];
    end else if (acc_sum < ACC_MIN_X) begin
      acc_nxt = ACC_MIN_X[ACC_W-1:0];
    end else begin
      acc_nxt = acc_sum[ACC_W-1:0];
    end
  end

  // Accumulator and counters; cleared when the result is loaded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= '0;
      elem_cnt_r <= '0;
      mism_cnt_r <= '0;
    end else if (cmd.finish) begin
      acc_r      <= '0;
      elem_cnt_r <= '0;
      mism_cnt_r <= '0;
    end else begin
      if (prod_vld_r) acc_r <= acc_nxt;
      if (cmd.take && elem_room) begin
        elem_cnt_r <= elem_cnt_r + CNT_W'(1);
        if (query_elem[ELEM_W-1] ^ cand_elem[ELEM_W-1]) begin
          mism_cnt_r <= mism_cnt_r + CNT_W'(1);
        end
      end
    end
  end

  // Norms are captured with every element; the last one's values remain.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      qn_r <= query_norm;
      cn_r <= cand_norm;
    end
  end

  // Norm product.
  always_ff @(posedge clk) begin
    if (cmd.norm) begin
      den_r <= qn_r * cn_r;
    end
  end

  // Magnitude of the finished dot product.
  assign mag = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);

  // One quotient bit per step: restoring division of rounded dividend.
  assign rem_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, dvs_r});
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      neg_r  <= acc_r[ACC_W-1];
      dvd_r  <= {mag, {FRAC_SH{1'b0}}} + DVD_W'(den_r);
      dvs_r  <= {den_r, 1'b0};
      rem_r  <= '0;
      quo_r  <= '0;
      ovf_r  <= 1'b0;
      step_r <= '0;
    end else if (cmd.step) begin
      dvd_r  <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r  <= rem_ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_r  <= {quo_r[QUO_W-2:0], rem_ge};
      ovf_r  <= ovf_r | quo_r[QUO_W-1];
      step_r <= step_r + STEP_W'(1);
    end
  end

  assign status.div_last = (step_r == STEP_W'(DIV_STEPS - 1));
  assign status.out_free = !out_valid_r || out_ch.ready;

  // Pass decision, saturation of the quotient and the reported count.
  assign mism_ext     = CMP_W'(mism_cnt_r);
  assign passed       = (mism_ext <= CMP_W'(max_mismatch_r));
  assign nonzero_norm = (qn_r != '0) && (cn_r != '0);
  assign mism_out     = (mism_ext > CMP_W'({MISM_W{1'b1}})) ? {MISM_W{1'b1}}
                                                             : mism_ext[MISM_W-1:0];

  always_comb begin
    if (!passed || !nonzero_norm) begin
      sim_val = '0;
    end else if (neg_r) begin
      if (ovf_r || quo_r > QUO_W'(32768)) begin
        sim_val = {1'b1, {(SIM_W-1){1'b0}}};
      end else begin
        sim_val = SIM_W'(~quo_r[SIM_W-1:0] + SIM_W'(1));
      end
    end else begin
      if (ovf_r || quo_r[QUO_W-1] || quo_r[SIM_W-1]) begin
        sim_val = {1'b0, {(SIM_W-1){1'b1}}};
      end else begin
        sim_val = quo_r[SIM_W-1:0];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_passed_r <= passed;
      out_sim_r    <= sim_val;
      out_mism_r   <= mism_out;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.passed     = out_passed_r;
  assign out_ch.similarity = out_sim_r;
  assign out_ch.mismatches = out_mism_r;

endmodule

### design/hamming_prefilter_cosine_similarity.sv
// Top level of the sign-prefiltered cosine similarity block.
// After the request that carries last: norm product, divider preparation, the
// 58-step bit-serial divider, then the result load once the output is free.
// Throughput: one element request per cycle while a vector streams in.
// Reset (rst_n, synchronous): counters and accumulator clear, limit becomes 64.
// Depends on hpcs_pkg, hpcs_if.sv, hpcs_ctrl and hpcs_datapath.
module hamming_prefilter_cosine_similarity (
  input  logic        clk,
  input  logic        rst_n,
  hpcs_in_if.sink     in_ch,
  hpcs_out_if.source  out_ch,
  hpcs_cfg_if.sink    cfg_ch
);
  import hpcs_pkg::*;

  hpcs_cmd_t    cmd;
  hpcs_status_t status;
  logic         in_ready;

  assign in_ch.ready = in_ready;

  // Sequencing of accumulate, norm product, division and result load.
  hpcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic and result register.
  hpcs_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .query_elem (in_ch.query_elem),
    .cand_elem  (in_ch.cand_elem),
    .query_norm (in_ch.query_norm),
    .cand_norm  (in_ch.cand_norm),
    .cmd        (cmd),
    .status     (status),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch)
  );

endmodule
